// ===== rtl/telemetry_frame_builder_sum_add_check_assert.svh =====
// Assertion macros shared by the frame builder RTL
`ifndef TELEMETRY_FRAME_BUILDER_SUM_ADD_CHECK_ASSERT_SVH
`define TELEMETRY_FRAME_BUILDER_SUM_ADD_CHECK_ASSERT_SVH

// Antecedent implies consequent in the same cycle, outside reset
`define TFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition never holds outside reset
`define TFB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/tfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tfb_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDRESS = 1'd1;
    localparam logic [7:0] HEADER_BYTE_RST  = 8'hAA;
    localparam logic [7:0] DEST_ADDRESS_RST = 8'hFF;

    // Input transaction
    typedef struct packed {
        logic [7:0] frame_id;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_end;
    } t_out;

    // Classified work item passed from front to back
    typedef struct packed {
        logic       first;
        logic       last;
        logic [7:0] header;
        logic [7:0] dest;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] data;
    } t_cmd;

    // Byte slot within one work item
    typedef enum logic [2:0] {
        STEP_HDR,
        STEP_DEST,
        STEP_ID,
        STEP_LEN,
        STEP_DATA,
        STEP_SUM,
        STEP_ADD
    } t_step;

    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ===== rtl/telemetry_frame_builder_sum_add_check.sv =====
// A transaction is registered in the command queue; the back sequencer then writes
// its frame bytes into the result queue, from which they are popped.
// Throughput: one output byte per cycle from the back sequencer while a command
// is queued and the result queue has room; an n-byte payload yields n + 6 frame bytes.
// Reset: synchronous, active low; clears queues, frame state and checks, and
// loads header byte 0xAA and destination address 0xFF.
`timescale 1ns / 1ps
`default_nettype none

`include "telemetry_frame_builder_sum_add_check_assert.svh"

module telemetry_frame_builder_sum_add_check (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tfb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tfb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire tfb_pkg::t_in                      i_item,
    input  wire logic                              pop,
    output logic                                   empty,
    output tfb_pkg::t_out                          o_result
);

    tfb_pkg::t_cmd w_cmd_in;
    tfb_pkg::t_cmd w_cmd_out;
    logic          w_accept;
    logic          w_cmd_valid;
    logic          w_cmd_pop;
    logic          w_res_end;
    logic          w_one_byte;

    assign w_accept = push && !full;

    // Classify incoming transactions
    tfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_item     (i_item),
        .o_cmd      (w_cmd_in)
    );

    // Decouple front and back
    tfb_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_cmd   (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_cmd_out),
        .o_valid (w_cmd_valid)
    );

    // Emit frame bytes
    tfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (o_result)
    );

    // Check invariants
    assign w_res_end  = !empty && o_result.frame_end;
    assign w_one_byte = w_accept && w_cmd_in.first && w_cmd_in.last;

    `TFB_ASSERT_IMPL(a_end_is_last, i_clk, i_rst_n, w_res_end, o_result.last_of_run)
    `TFB_ASSERT_NEVER(a_pop_without_cmd, i_clk, i_rst_n, w_cmd_pop && !w_cmd_valid)
    `TFB_ASSERT_IMPL(a_single_byte_len, i_clk, i_rst_n, w_one_byte, w_cmd_in.len == 8'd1)

endmodule

`default_nettype wire

// ===== rtl/tfb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tfb_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tfb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tfb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_accept,
    input  wire tfb_pkg::t_in                      i_item,
    output tfb_pkg::t_cmd                          o_cmd
);

    logic       r_in_frame;
    logic [7:0] r_remaining;
    logic [7:0] r_header;
    logic [7:0] r_dest;

    logic [7:0] w_len_eff;
    logic [7:0] w_rem_cur;
    logic [7:0] w_rem_next;

    // Classify: first byte of a frame, last byte of a frame
    always_comb begin
        w_len_eff  = (i_item.payload_length == 8'd0) ? 8'd1 : i_item.payload_length;
        w_rem_cur  = r_in_frame ? r_remaining : w_len_eff;
        w_rem_next = w_rem_cur - 8'd1;

        o_cmd.first  = !r_in_frame;
        o_cmd.last   = (w_rem_next == 8'd0);
        o_cmd.header = r_header;
        o_cmd.dest   = r_dest;
        o_cmd.id     = i_item.frame_id;
        o_cmd.len    = w_len_eff;
        o_cmd.data   = i_item.data_byte;
    end

    // Track frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_remaining <= 8'd0;
        end else if (i_accept) begin
            r_in_frame  <= (w_rem_next != 8'd0);
            r_remaining <= w_rem_next;
        end
    end

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= tfb_pkg::HEADER_BYTE_RST;
            r_dest   <= tfb_pkg::DEST_ADDRESS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tfb_pkg::CFG_HEADER_BYTE:  r_header <= i_cfg_data;
                tfb_pkg::CFG_DEST_ADDRESS: r_dest   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tfb_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tfb_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tfb_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output tfb_pkg::t_cmd      o_cmd,
    output logic               o_valid
);

    tfb_pkg::t_cmd r_mem [tfb_pkg::QUEUE_DEPTH];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == 2'(tfb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tfb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tfb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tfb_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output tfb_pkg::t_out      o_res
);

    tfb_pkg::t_step r_step;
    tfb_pkg::t_step n_step;
    logic           r_busy;
    logic           n_busy;
    logic [7:0]     r_sum;
    logic [7:0]     r_add;

    tfb_pkg::t_out  r_oq [tfb_pkg::QUEUE_DEPTH];
    logic           r_owr;
    logic           r_ord;
    logic [1:0]     r_ocnt;

    tfb_pkg::t_step w_cur;
    tfb_pkg::t_out  w_res;
    logic           w_room;
    logic           w_emit;
    logic           w_running;
    logic [7:0]     w_sum_new;
    logic [7:0]     w_add_new;
    logic           w_opop;

    assign w_room  = (r_ocnt != 2'(tfb_pkg::QUEUE_DEPTH));
    assign w_emit  = i_cmd_valid && w_room;
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_ord];
    assign w_opop  = i_pop && !o_empty;

    // Pick the byte slot, the output byte and the next slot
    always_comb begin
        if (r_busy) begin
            w_cur = r_step;
        end else begin
            w_cur = i_cmd.first ? tfb_pkg::STEP_HDR : tfb_pkg::STEP_DATA;
        end

        w_res.out_byte    = i_cmd.data;
        w_res.last_of_run = 1'b0;
        w_res.frame_end   = 1'b0;
        w_running         = 1'b1;
        n_step            = r_step;
        n_busy            = r_busy;
        case (w_cur)
            tfb_pkg::STEP_HDR: begin
                w_res.out_byte = i_cmd.header;
                n_step         = tfb_pkg::STEP_DEST;
            end
            tfb_pkg::STEP_DEST: begin
                w_res.out_byte = i_cmd.dest;
                n_step         = tfb_pkg::STEP_ID;
            end
            tfb_pkg::STEP_ID: begin
                w_res.out_byte = i_cmd.id;
                n_step         = tfb_pkg::STEP_LEN;
            end
            tfb_pkg::STEP_LEN: begin
                w_res.out_byte = i_cmd.len;
                n_step         = tfb_pkg::STEP_DATA;
            end
            tfb_pkg::STEP_DATA: begin
                w_res.out_byte    = i_cmd.data;
                w_res.last_of_run = !i_cmd.last;
                n_step            = tfb_pkg::STEP_SUM;
            end
            tfb_pkg::STEP_SUM: begin
                w_res.out_byte = r_sum;
                w_running      = 1'b0;
                n_step         = tfb_pkg::STEP_ADD;
            end
            tfb_pkg::STEP_ADD: begin
                w_res.out_byte    = r_add;
                w_res.last_of_run = 1'b1;
                w_res.frame_end   = 1'b1;
                w_running         = 1'b0;
                n_step            = tfb_pkg::STEP_HDR;
            end
            default: begin
                w_running = 1'b0;
                n_step    = tfb_pkg::STEP_HDR;
            end
        endcase

        if (w_emit) begin
            n_busy = !w_res.last_of_run;
        end else begin
            n_step = r_step;
        end

        // Restart both sums on the header byte
        w_sum_new = ((w_cur == tfb_pkg::STEP_HDR) ? 8'd0 : r_sum) + w_res.out_byte;
        w_add_new = ((w_cur == tfb_pkg::STEP_HDR) ? 8'd0 : r_add) + w_sum_new;

        o_cmd_pop = w_emit && w_res.last_of_run;
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tfb_pkg::STEP_HDR;
            r_busy <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
        end
    end

    // Accumulate running checks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 8'd0;
            r_add <= 8'd0;
        end else if (w_emit && w_running) begin
            r_sum <= w_sum_new;
            r_add <= w_add_new;
        end
    end

    // Store emitted results
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_oq[r_owr] <= w_res;
        end
    end

    // Advance result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_emit) begin
                r_owr <= ~r_owr;
            end
            if (w_opop) begin
                r_ord <= ~r_ord;
            end
            r_ocnt <= r_ocnt + 2'(w_emit) - 2'(w_opop);
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import tfb_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int MAX_CYCLES      = 400000;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // One step of the directed plan: a transaction or a register load
    typedef struct {
        row_kind_t  kind;
        t_in        item;
        logic [7:0] hdr;
        logic [7:0] dest;
        bit         known;
        logic [7:0] want_sum;
        logic [7:0] want_add;
    } plan_row_t;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push       = 1'b0;
    logic                  full;
    t_in                   i_item     = '0;
    logic                  pop        = 1'b0;
    logic                  empty;
    t_out                  o_result;

    // Frame builder shadow state
    logic [7:0] hdr_reg  = HEADER_BYTE_RST;
    logic [7:0] dest_reg = DEST_ADDRESS_RST;
    bit         fb_open  = 1'b0;
    logic [7:0] fb_left  = 8'd0;
    logic [7:0] fb_sum   = 8'd0;
    logic [7:0] fb_add   = 8'd0;
    t_out       frame_q[$];

    // Traffic control shared by sender and receiver
    bit  steady      = 1'b0;
    int  stall_token = 0;
    int  stall_seen  = 0;
    int  hold_left   = 0;
    int  rx_gap      = 0;
    int  bad_count   = 0;
    int  cycle_count = 0;

    plan_row_t plan[$];

    telemetry_frame_builder_sum_add_check dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .pop        (pop),
        .empty      (empty),
        .o_result   (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    // Append one frame byte, folding it into the running checks if asked
    function automatic void put_frame_byte(logic [7:0] b, bit running, bit closing);
        t_out r;
        if (running) begin
            fb_sum = fb_sum + b;
            fb_add = fb_add + fb_sum;
        end
        r.out_byte    = b;
        r.last_of_run = 1'b0;
        r.frame_end   = closing;
        frame_q.push_back(r);
    endfunction

    // Expand one payload byte into the frame bytes it releases
    function automatic void build_frame_bytes(t_in it);
        logic [7:0] len;
        t_out       r;
        len = it.payload_length;
        if (!fb_open) begin
            if (len == 8'd0) len = 8'd1;
            fb_sum = 8'd0;
            fb_add = 8'd0;
            put_frame_byte(hdr_reg, 1'b1, 1'b0);
            put_frame_byte(dest_reg, 1'b1, 1'b0);
            put_frame_byte(it.frame_id, 1'b1, 1'b0);
            put_frame_byte(len, 1'b1, 1'b0);
            fb_left = len;
            fb_open = 1'b1;
        end
        put_frame_byte(it.data_byte, 1'b1, 1'b0);
        if (fb_left != 8'd0) fb_left = fb_left - 8'd1;
        if (fb_left == 8'd0) begin
            put_frame_byte(fb_sum, 1'b0, 1'b0);
            put_frame_byte(fb_add, 1'b0, 1'b1);
            fb_open = 1'b0;
            fb_sum  = 8'd0;
            fb_add  = 8'd0;
        end
        r = frame_q.pop_back();
        r.last_of_run = 1'b1;
        frame_q.push_back(r);
    endfunction

    // Frame start bytes get a drawn length, mid-frame bytes carry noise there
    function automatic t_in random_item();
        t_in it;
        int  r;
        it.frame_id  = 8'($urandom_range(0, 255));
        it.data_byte = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (fb_open)      it.payload_length = 8'($urandom_range(0, 255));
        else if (r < 10)  it.payload_length = 8'd0;
        else if (r < 70)  it.payload_length = 8'($urandom_range(1, 4));
        else if (r < 95)  it.payload_length = 8'($urandom_range(5, 12));
        else              it.payload_length = 8'($urandom_range(13, 40));
        return it;
    endfunction

    function automatic plan_row_t mk_item(logic [7:0] id, logic [7:0] len, logic [7:0] data,
                                          bit known, logic [7:0] ws, logic [7:0] wa);
        plan_row_t row;
        row.kind                = ROW_ITEM;
        row.item.frame_id       = id;
        row.item.payload_length = len;
        row.item.data_byte      = data;
        row.hdr                 = 8'd0;
        row.dest                = 8'd0;
        row.known               = known;
        row.want_sum            = ws;
        row.want_add            = wa;
        return row;
    endfunction

    function automatic plan_row_t mk_cfg(logic [7:0] h, logic [7:0] d);
        plan_row_t row;
        row          = mk_item(8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
        row.kind     = ROW_CFG;
        row.hdr      = h;
        row.dest     = d;
        return row;
    endfunction

    // Offer one transaction and hold it until the block takes it
    task automatic send_item(input t_in it);
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        build_frame_bytes(it);
    endtask

    task automatic sender_gap();
        int g;
        g = steady ? 0 : pick_gap();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected byte has come out
    task automatic drain();
        push <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_regs(logic [7:0] h, logic [7:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HEADER_BYTE;
        i_cfg_data <= h;
        @(posedge i_clk);
        hdr_reg = h;
        i_cfg_idx  <= CFG_DEST_ADDRESS;
        i_cfg_data <= d;
        @(posedge i_clk);
        dest_reg = d;
        i_cfg_we <= 1'b0;
    endtask

    task automatic report_bad(string what, t_out want, t_out got);
        if (bad_count < MAX_REPORTS)
            $display("%s: want byte %02h last %0d end %0d, got byte %02h last %0d end %0d",
                     what, want.out_byte, want.last_of_run, want.frame_end,
                     got.out_byte, got.last_of_run, got.frame_end);
        bad_count++;
    endtask

    // Receiver: check each popped transaction, then decide the next pop
    always @(posedge i_clk) begin
        t_out want;
        if (pop && !empty) begin
            if (frame_q.size() == 0) begin
                want = '0;
                report_bad("unexpected result", want, o_result);
            end else begin
                want = frame_q.pop_front();
                if (o_result.out_byte !== want.out_byte ||
                    o_result.last_of_run !== want.last_of_run ||
                    o_result.frame_end !== want.frame_end)
                    report_bad("mismatch", want, o_result);
            end
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            hold_left  = HOLD_CYCLES;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            rx_gap = steady ? 0 : pick_gap();
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        plan_row_t  row;
        logic [7:0] h;
        logic [7:0] d;
        t_out       r_sum;
        t_out       r_add;

        // Zero length and all-ones bytes with reset registers
        plan.push_back(mk_item(8'h00, 8'h00, 8'h00, 1'b1, 8'hAA, 8'h50));
        plan.push_back(mk_item(8'hFF, 8'h01, 8'hFF, 1'b1, 8'hA8, 8'h4C));
        // Length and id ignored after the first byte
        plan.push_back(mk_item(8'h30, 8'h03, 8'h12, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_item(8'h41, 8'h00, 8'h34, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_item(8'hF1, 8'hFF, 8'h56, 1'b0, 8'h00, 8'h00));
        // Register load in the middle of a frame lands on the next header
        plan.push_back(mk_item(8'h41, 8'h02, 8'h80, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_cfg(8'h00, 8'h00));
        plan.push_back(mk_item(8'h00, 8'h00, 8'hFF, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_item(8'hF1, 8'h01, 8'h7F, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_cfg(8'hFF, 8'hFF));
        plan.push_back(mk_item(8'h80, 8'h05, 8'h01, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_item(8'h7F, 8'hFF, 8'hFE, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_item(8'h01, 8'h80, 8'h00, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_item(8'hFE, 8'h7F, 8'hAA, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_item(8'h00, 8'h01, 8'h55, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_cfg(8'hAA, 8'hFF));
        plan.push_back(mk_item(8'h30, 8'h01, 8'h00, 1'b0, 8'h00, 8'h00));
        plan.push_back(mk_item(8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00, 8'h00));

        // Hold reset, then release
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed plan
        for (int k = 0; k < plan.size(); k++) begin
            row = plan[k];
            if (row.kind == ROW_CFG) begin
                drain();
                load_regs(row.hdr, row.dest);
            end else begin
                send_item(row.item);
                if (row.known) begin
                    r_add = frame_q.pop_back();
                    r_sum = frame_q.pop_back();
                    r_sum.out_byte = row.want_sum;
                    r_add.out_byte = row.want_add;
                    frame_q.push_back(r_sum);
                    frame_q.push_back(r_add);
                end
                sender_gap();
            end
        end
        drain();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin h = 8'h00; d = 8'hFF; end
                1:       begin h = 8'hFF; d = 8'h00; end
                default: begin
                    h = 8'($urandom_range(0, 255));
                    d = 8'($urandom_range(0, 255));
                end
            endcase
            load_regs(h, d);
            // Back-pressure phase: receiver stalls while the sender keeps offering
            if (ph == 2) stall_token <= stall_token + 1;
            steady <= (ph == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_item());
                sender_gap();
            end
            drain();
        end

        if (bad_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
